@@ hw/rtl/tkct_pkg.sv @@
// tkct_pkg: types, sizes and command codes of the two-level keyed code table
// used by the slot cells and the top level; no dependencies
`timescale 1ns / 1ps

package tkct_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 16;
  localparam int CODE_W  = 16;
  localparam int STORE_W = 15;

  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_SET_BS  = 2'd1;
  localparam logic [1:0] ACT_SET_OV  = 2'd2;
  localparam logic [1:0] ACT_LOOKUP  = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic [KEY_W-1:0]         freq;
    logic signed [CODE_W-1:0] code;
  } tkct_cmd_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] code_out;
    logic                     found;
    logic                     table_full;
  } tkct_rsp_t;

  // token that walks the cell row, low slot to high slot
  typedef struct packed {
    logic                vld;
    logic [1:0]          action;
    logic [KEY_W-1:0]    key;
    logic [CODE_W-1:0]   code;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                emp;
    logic [IDX_W-1:0]    emp_idx;
    logic                ov_hit;
    logic [STORE_W-1:0]  ov_code;
    logic                bs_hit;
    logic [STORE_W-1:0]  bs_code;
  } tkct_tok_t;

  // update broadcast to all cells
  typedef struct packed {
    logic                clear;
    logic                en;
    logic                ovr;
    logic [IDX_W-1:0]    slot;
    logic [KEY_W-1:0]    key;
    logic [STORE_W-1:0]  code;
  } tkct_wr_t;

endpackage

@@ hw/rtl/tkct_cell.sv @@
// tkct_cell: one slot of both tables plus one stage of the scan token
// depends on tkct_pkg
`timescale 1ns / 1ps

module tkct_cell
  import tkct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] slot,
  input  tkct_tok_t        tok_in,
  input  tkct_wr_t         wr,
  output tkct_tok_t        tok_out
);

  logic [KEY_W-1:0]   bkey;
  logic [STORE_W-1:0] bcode;
  logic [KEY_W-1:0]   okey;
  logic [STORE_W-1:0] ocode;
  tkct_tok_t          tok_next;
  logic [KEY_W-1:0]   sel_key;

  always_comb begin
    tok_next = tok_in;
    sel_key  = (tok_in.action == ACT_SET_OV) ? okey : bkey;
    if (sel_key == tok_in.key) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = slot;
    end
    if (sel_key == '0 && !tok_in.emp) begin
      tok_next.emp     = 1'b1;
      tok_next.emp_idx = slot;
    end
    if (okey == tok_in.key) begin
      tok_next.ov_hit  = 1'b1;
      tok_next.ov_code = ocode;
    end
    if (bkey == tok_in.key) begin
      tok_next.bs_hit  = 1'b1;
      tok_next.bs_code = bcode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      bkey  <= '0;
      bcode <= '0;
      okey  <= '0;
      ocode <= '0;
    end else if (wr.en && wr.slot == slot) begin
      if (wr.ovr) begin
        okey  <= wr.key;
        ocode <= wr.code;
      end else begin
        bkey  <= wr.key;
        bcode <= wr.code;
      end
    end
  end

endmodule

@@ hw/rtl/two_level_keyed_code_table.sv @@
// two_level_keyed_code_table: top level, command sequencer and row of slot cells
// depends on tkct_pkg and tkct_cell
//
//   channel | valid     | stall     | payload
//   command | cmd_valid | cmd_stall | cmd (tkct_cmd_t)
//   result  | rsp_valid | rsp_stall | rsp (tkct_rsp_t)
//
// each command: a token walks the cell row one slot per cycle, the finished token
// is registered, then the final step forms the result and applies the update
// one result per command
// cmd_stall is high while a command is in flight
// a stalled result holds the sequencer in its final step; reset empties both tables
`timescale 1ns / 1ps

module two_level_keyed_code_table
  import tkct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  tkct_cmd_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output tkct_rsp_t rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  tkct_tok_t          link [ENTRIES+1];
  logic [ENTRIES-1:0] tok_vld;
  tkct_tok_t          fin;
  tkct_wr_t           wr;
  tkct_rsp_t          rsp_next;
  logic               accept;
  logic               emit;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign emit      = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    link[0]         = '0;
    link[0].vld     = accept;
    link[0].action  = cmd.action;
    link[0].key     = cmd.freq;
    link[0].code    = cmd.code;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tkct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .slot    (IDX_W'(g)),
      .tok_in  (link[g]),
      .wr      (wr),
      .tok_out (link[g+1])
    );
    assign tok_vld[g] = link[g+1].vld;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (link[ENTRIES].vld) state_next = ST_DONE;
      ST_DONE: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && link[ENTRIES].vld) begin
      fin <= link[ENTRIES];
    end
  end

  // result and table update from the finished token
  always_comb begin
    rsp_next = '0;
    wr       = '0;
    wr.ovr   = (fin.action == ACT_SET_OV);
    wr.slot  = fin.hit ? fin.hit_idx : fin.emp_idx;
    if (!fin.code[CODE_W-1]) begin
      wr.key  = fin.key;
      wr.code = fin.code[STORE_W-1:0];
    end
    unique case (fin.action)
      ACT_CLEAR: begin
        wr.clear = emit;
      end
      ACT_SET_BS, ACT_SET_OV: begin
        wr.en               = emit && (fin.hit || fin.emp);
        rsp_next.table_full = !(fin.hit || fin.emp);
      end
      ACT_LOOKUP: begin
        rsp_next.found = fin.ov_hit || fin.bs_hit;
        if (fin.ov_hit) begin
          rsp_next.code_out = signed'({1'b0, fin.ov_code});
        end else if (fin.bs_hit) begin
          rsp_next.code_out = signed'({1'b0, fin.bs_code});
        end else begin
          rsp_next.code_out = '1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  // at most one token in the cell row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vld) <= 1)
    else $error("more than one token in the cell row");

  // a token leaves the row only while the sequencer waits for it
  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    link[ENTRIES].vld |-> state == ST_SCAN)
    else $error("token left the row outside the scan step");

  // table updates happen only in the final step
  a_wr_in_done: assert property (@(posedge clk) disable iff (rst)
    (wr.en || wr.clear) |-> state == ST_DONE)
    else $error("table update outside the final step");

  // a full flag never comes with a hit
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.table_full && rsp.found))
    else $error("full and found both set");

endmodule

@@ dv/tkct_checker.sv @@
// tkct_checker: watches the command and result channels of two_level_keyed_code_table,
// keeps its own copy of both key/code tables and compares every result transfer
// depends on tkct_pkg
`timescale 1ns / 1ps

module tkct_checker
  import tkct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_stall,
  input  tkct_cmd_t cmd,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  tkct_rsp_t rsp,
  output int        errors,
  output int        pending
);

  localparam int TBL_BASE = 0;
  localparam int TBL_OVR  = 1;

  logic [KEY_W-1:0]   slot_key  [2][ENTRIES];
  logic [STORE_W-1:0] slot_code [2][ENTRIES];
  tkct_rsp_t          replies_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void wipe_tables();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      slot_key[TBL_BASE][i]  = '0;
      slot_code[TBL_BASE][i] = '0;
      slot_key[TBL_OVR][i]   = '0;
      slot_code[TBL_OVR][i]  = '0;
    end
  endfunction

  // highest matching slot, else lowest empty slot, else -1
  function automatic int choose_slot(int tbl, logic [KEY_W-1:0] key);
    int i;
    int emp;
    emp = -1;
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_key[tbl][i] == key) return i;
      if (slot_key[tbl][i] == '0) emp = i;
    end
    return emp;
  endfunction

  function automatic tkct_rsp_t apply_command(tkct_cmd_t c);
    tkct_rsp_t r;
    int        tbl;
    int        s;
    r = '0;
    case (c.action)
      ACT_CLEAR: begin
        wipe_tables();
      end
      ACT_SET_BS, ACT_SET_OV: begin
        tbl = (c.action == ACT_SET_OV) ? TBL_OVR : TBL_BASE;
        s = choose_slot(tbl, c.freq);
        if (s < 0) begin
          r.table_full = 1'b1;
        end else if (c.code[CODE_W-1]) begin
          slot_key[tbl][s]  = '0;
          slot_code[tbl][s] = '0;
        end else begin
          slot_key[tbl][s]  = c.freq;
          slot_code[tbl][s] = c.code[STORE_W-1:0];
        end
      end
      default: begin
        r.code_out = -16'sd1;
        s = choose_slot(TBL_OVR, c.freq);
        if (s >= 0 && slot_key[TBL_OVR][s] == c.freq) begin
          r.code_out = {1'b0, slot_code[TBL_OVR][s]};
          r.found    = 1'b1;
        end else begin
          s = choose_slot(TBL_BASE, c.freq);
          if (s >= 0 && slot_key[TBL_BASE][s] == c.freq) begin
            r.code_out = {1'b0, slot_code[TBL_BASE][s]};
            r.found    = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    tkct_rsp_t want;
    int        bad;
    bad = 0;
    if (rst) begin
      wipe_tables();
      replies_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t unexpected result transfer: expected none,", $time,
                   " actual code_out=%0d found=%0b table_full=%0b",
                   rsp.code_out, rsp.found, rsp.table_full);
          bad = 1;
        end else begin
          want = replies_due.pop_front();
          if (rsp.code_out !== want.code_out || rsp.found !== want.found ||
              rsp.table_full !== want.table_full) begin
            $display("%0t result mismatch:", $time,
                     " expected code_out=%0d found=%0b table_full=%0b,",
                     want.code_out, want.found, want.table_full,
                     " actual code_out=%0d found=%0b table_full=%0b",
                     rsp.code_out, rsp.found, rsp.table_full);
            bad = 1;
          end
        end
      end
      if (cmd_valid && !cmd_stall) replies_due.push_back(apply_command(cmd));
    end
    errors  <= errors + bad;
    pending <= replies_due.size();
  end

endmodule

@@ dv/tb.sv @@
// tb: stimulus, flow control and verdict for two_level_keyed_code_table
// depends on tkct_pkg, the block and tkct_checker
`timescale 1ns / 1ps

module tb;
  import tkct_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int RAND_ITEMS = 900;
  localparam int POOL_N     = 12;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  tkct_cmd_t cmd       = '0;
  logic      cmd_stall;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  tkct_rsp_t rsp;
  int        errors;
  int        pending;
  int        cycles;
  int        tx_pct = 0;
  int        rx_pct = 0;
  logic [KEY_W-1:0] key_pool [POOL_N];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_level_keyed_code_table DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  tkct_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < rx_pct);
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("two_level_keyed_code_table verification failed");
    $finish;
  end

  function automatic tkct_cmd_t mk(logic [1:0] act, logic [KEY_W-1:0] key,
                                   logic [CODE_W-1:0] code);
    tkct_cmd_t c;
    c.action = act;
    c.freq   = key;
    c.code   = code;
    return c;
  endfunction

  function automatic tkct_cmd_t random_cmd();
    int                r;
    logic [1:0]        act;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
    r = $urandom_range(99);
    if (r < 3)       act = ACT_CLEAR;
    else if (r < 33) act = ACT_SET_BS;
    else if (r < 58) act = ACT_SET_OV;
    else             act = ACT_LOOKUP;
    r = $urandom_range(99);
    if (r < 80)      key = key_pool[$urandom_range(POOL_N - 1)];
    else if (r < 85) key = '0;
    else             key = KEY_W'($urandom());
    r = $urandom_range(99);
    if (r < 20) begin
      code = CODE_W'($urandom());
      code[CODE_W-1] = 1'b1;
    end else if (r < 30) begin
      case ($urandom_range(3))
        0:       code = 16'h0000;
        1:       code = 16'h7FFF;
        2:       code = 16'h8000;
        default: code = 16'hFFFF;
      endcase
    end else begin
      code = CODE_W'($urandom());
      code[CODE_W-1] = 1'b0;
    end
    return mk(act, key, code);
  endfunction

  task automatic issue_cmd(tkct_cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_pct) gap++;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    int ph;
    int k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tables, extremes, override priority, delete, key zero, full
    issue_cmd(mk(ACT_CLEAR, 16'h0000, 16'h0000));
    issue_cmd(mk(ACT_LOOKUP, 16'h0000, 16'h1234));
    issue_cmd(mk(ACT_SET_BS, 16'hFFFF, 16'h7FFF));
    issue_cmd(mk(ACT_LOOKUP, 16'hFFFF, 16'h0000));
    issue_cmd(mk(ACT_SET_OV, 16'hFFFF, 16'h0000));
    issue_cmd(mk(ACT_LOOKUP, 16'hFFFF, 16'hFFFF));
    issue_cmd(mk(ACT_SET_OV, 16'hFFFF, 16'h8000));
    issue_cmd(mk(ACT_LOOKUP, 16'hFFFF, 16'h0000));
    issue_cmd(mk(ACT_SET_BS, 16'h0000, 16'h0005));
    issue_cmd(mk(ACT_LOOKUP, 16'h0000, 16'h0000));
    issue_cmd(mk(ACT_SET_BS, 16'h1234, 16'hFFFF));
    for (i = 1; i < ENTRIES; i++) begin
      issue_cmd(mk(ACT_SET_BS, KEY_W'(i), CODE_W'(16'h0100 + i)));
    end
    issue_cmd(mk(ACT_SET_BS, 16'h0009, 16'h0001));
    issue_cmd(mk(ACT_LOOKUP, 16'h0000, 16'h0000));
    issue_cmd(mk(ACT_LOOKUP, 16'h5555, 16'h0000));
    issue_cmd(mk(ACT_SET_BS, 16'h0003, 16'h0064));
    issue_cmd(mk(ACT_LOOKUP, 16'h0003, 16'h0000));
    issue_cmd(mk(ACT_CLEAR, 16'hAAAA, 16'h5555));
    issue_cmd(mk(ACT_LOOKUP, 16'h0003, 16'h0000));
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_pct <= 0;  rx_pct <= 0;  end
        1:       begin tx_pct <= 81; rx_pct <= 0;  end
        2:       begin tx_pct <= 0;  rx_pct <= 81; end
        default: begin tx_pct <= 15; rx_pct <= 15; end
      endcase
      for (k = 0; k < POOL_N; k++) key_pool[k] = KEY_W'($urandom_range(65535, 1));
      @(posedge clk);
      for (i = 0; i < RAND_ITEMS / 4; i++) begin
        issue_cmd(random_cmd());
        if (i == RAND_ITEMS / 8) drain();
      end
      drain();
    end

    repeat (ENTRIES + 4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("two_level_keyed_code_table verification clean");
    end else begin
      $display("two_level_keyed_code_table verification failed");
    end
    $finish;
  end

endmodule

@@ two_level_keyed_code_table.f @@
hw/rtl/tkct_pkg.sv
hw/rtl/tkct_cell.sv
hw/rtl/two_level_keyed_code_table.sv
dv/tkct_checker.sv
dv/tb.sv
